// ===== src/lcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame encoder package
// Shared types, frame layout constants and the CRC column function.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfe_pkg;

  localparam int unsigned FRAME_LEN   = 14;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned CRC_W       = 32;

  localparam logic [7:0]       START_BYTE = 8'hF5;
  localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C11DB7;
  localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [CRC_W-1:0] CRC_TOP    = 32'h80000000;

  // Frame byte positions.
  localparam logic [3:0] POS_START    = 4'd0;
  localparam logic [3:0] POS_CODE     = 4'd1;
  localparam logic [3:0] POS_PAYLOAD0 = 4'd2;
  localparam logic [3:0] POS_CRC0     = 4'd10;
  localparam logic [3:0] POS_LAST     = 4'd13;

  typedef struct packed {
    logic [7:0]                  code;
    logic [PAYLOAD_LEN-1:0][7:0] payload;
  } cmd_t;

  // Column i of the word-fed update: x^(i+32) mod P. Only evaluated on
  // constants, so the loop folds away at elaboration.
  function automatic logic [CRC_W-1:0] crc_col(input int unsigned bit_idx);
    logic [CRC_W-1:0] r;
    r = CRC_W'(1) << bit_idx;
    for (int unsigned n = 0; n < CRC_W; n++) begin
      if ((r & CRC_TOP) != '0) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/lcfe_front.sv =====
// ----------------------------------------------------------------------------
// Command frame encoder front end
// Accepts command requests and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [7:0]    in_command_code,
  input  wire logic [7:0]    in_payload_0,
  input  wire logic [7:0]    in_payload_1,
  input  wire logic [7:0]    in_payload_2,
  input  wire logic [7:0]    in_payload_3,
  input  wire logic [7:0]    in_payload_4,
  input  wire logic [7:0]    in_payload_5,
  input  wire logic [7:0]    in_payload_6,
  input  wire logic [7:0]    in_payload_7,
  output logic               q_valid,
  output lcfe_pkg::cmd_t     q_cmd,
  input  wire logic          q_pop
);
  import lcfe_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.code       = in_command_code;
    in_cmd.payload[0] = in_payload_0;
    in_cmd.payload[1] = in_payload_1;
    in_cmd.payload[2] = in_payload_2;
    in_cmd.payload[3] = in_payload_3;
    in_cmd.payload[4] = in_payload_4;
    in_cmd.payload[5] = in_payload_5;
    in_cmd.payload[6] = in_payload_6;
    in_cmd.payload[7] = in_payload_7;
  end

  assign busy    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/lcfe_back.sv =====
// ----------------------------------------------------------------------------
// Command frame encoder back end
// Streams the fourteen frame bytes and runs the CRC one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  lcfe_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output logic [7:0]          out_frame_byte,
  output logic                out_last_byte
);
  import lcfe_pkg::*;

  logic             active_r;
  logic [3:0]       idx_r;
  cmd_t             cmd_r;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] crc_fed;
  logic [CRC_W-1:0] col_w [CRC_W];
  logic [7:0]       cur_byte;
  logic [3:0]       pay_idx;
  logic [3:0]       crc_idx;
  logic             finishing;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r;

  genvar g;
  generate
    for (g = 0; g < CRC_W; g++) begin : g_col
      assign col_w[g] = crc_col(g);
    end
  endgenerate

  assign pay_idx = idx_r - POS_PAYLOAD0;
  assign crc_idx = idx_r - POS_CRC0;

  always_comb begin
    priority if (idx_r == POS_START) begin
      cur_byte = START_BYTE;
    end else if (idx_r == POS_CODE) begin
      cur_byte = cmd_r.code;
    end else if (idx_r < POS_CRC0) begin
      cur_byte = cmd_r.payload[pay_idx[2:0]];
    end else begin
      cur_byte = crc_r[{crc_idx[1:0], 3'b000} +: 8];
    end
  end

  // The 32 shifts after each byte are linear, so they reduce to one XOR
  // of constant columns selected by the register bits.
  assign crc_fed = crc_r ^ {24'd0, cur_byte};

  always_comb begin
    crc_nxt = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (crc_fed[i]) begin
        crc_nxt = crc_nxt ^ col_w[i];
      end
    end
  end

  assign finishing = active_r && (idx_r == POS_LAST);
  assign q_pop     = q_valid && (!active_r || finishing);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (q_pop) begin
      crc_r <= CRC_INIT;
    end else if (active_r && (idx_r < POS_CRC0)) begin
      crc_r <= crc_nxt;
    end
    byte_r <= cur_byte;
    last_r <= finishing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= POS_START;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= active_r;
      if (q_pop) begin
        active_r <= 1'b1;
        idx_r    <= POS_START;
      end else if (finishing) begin
        active_r <= 1'b0;
        idx_r    <= POS_START;
      end else if (active_r) begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

`default_nettype wire

// ===== src/lidar_command_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Lidar command frame encoder
// Turns one command request into a fourteen-byte frame with a CRC-32 trailer.
// ----------------------------------------------------------------------------
// Usage:
//   A command request is taken at a rising edge where start is high and busy
//   is low. It carries the opcode and eight payload bytes.
//   The block emits the frame one byte per cycle on out_frame_byte, each byte
//   marked by out_valid for exactly one cycle: start byte 0xF5, the opcode,
//   the eight payload bytes, then the CRC-32 low byte first. out_last_byte
//   flags the final CRC byte.
//   The CRC uses polynomial 0x04C11DB7, starts at all ones, has no final
//   inversion, and feeds each of the first ten bytes into the low bits of
//   the register followed by a full 32-bit shift, one byte per cycle.
//   When the block is idle, an accepted request is written into the queue,
//   popped into the back end's command register, and its first frame byte
//   then passes through the output register.
//   Frames can leave back to back, paced by the byte-wide output of the
//   back end. A two-entry queue between the front end and the back end lets
//   the next requests land while a frame is still streaming; busy is high
//   only when both entries are full.
//   Reset empties the queue and stops any frame in flight. The receiver
//   cannot stall: every byte is shown once and must be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_command_frame_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_command_code,
  input  wire logic [7:0] in_payload_0,
  input  wire logic [7:0] in_payload_1,
  input  wire logic [7:0] in_payload_2,
  input  wire logic [7:0] in_payload_3,
  input  wire logic [7:0] in_payload_4,
  input  wire logic [7:0] in_payload_5,
  input  wire logic [7:0] in_payload_6,
  input  wire logic [7:0] in_payload_7,
  output logic            out_valid,
  output logic [7:0]      out_frame_byte,
  output logic            out_last_byte
);
  import lcfe_pkg::*;

  // Queue head as seen by the back end.
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // The front end captures requests into the queue.
  lcfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command_code (in_command_code),
    .in_payload_0    (in_payload_0),
    .in_payload_1    (in_payload_1),
    .in_payload_2    (in_payload_2),
    .in_payload_3    (in_payload_3),
    .in_payload_4    (in_payload_4),
    .in_payload_5    (in_payload_5),
    .in_payload_6    (in_payload_6),
    .in_payload_7    (in_payload_7),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop)
  );

  // The back end pops a command on the cycle its previous frame ends, so
  // frames follow each other without a gap.
  lcfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire
